FILE: hdl/toy_register_machine_execute_core_defines.svh
// ----------------------------------------------------------------------------
// Toy register machine execute core - assertion macros
// Shorthand for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef TOY_REGISTER_MACHINE_EXECUTE_CORE_DEFINES_SVH
`define TOY_REGISTER_MACHINE_EXECUTE_CORE_DEFINES_SVH

// check that is off while reset is asserted
`define TRME_CHK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check that also runs through reset
`define TRME_CHK_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/trme_pkg.sv
// ----------------------------------------------------------------------------
// Toy register machine execute package
// Field widths, operation and status codes, and the shared unit's control.
// ----------------------------------------------------------------------------
package trme_pkg;

    localparam int NUM_REGS_DEF   = 4;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int TYPE_W = 3;
    localparam int RIDX_W = 2;
    localparam int IMM_W  = 32;
    localparam int ST_W   = 3;
    localparam int LC_W   = 16;
    localparam int PC_W   = 16;
    localparam int OUT_W  = 32;
    localparam int MAG_W  = 32;
    localparam int ACC_W  = 34;

    localparam logic [RIDX_W-1:0] CHK_REG = 2'd2;

    typedef enum logic [TYPE_W-1:0] {
        OP_MOV = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_INC = 3'd5,
        OP_DEC = 3'd6,
        OP_JNZ = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_OVF      = 3'd1,
        ST_DIV0     = 3'd2,
        ST_NEG      = 3'd3,
        ST_RANGE    = 3'd4,
        ST_NOTTAKEN = 3'd5
    } t_status;

    typedef struct packed {
        logic load;
        logic step;
        t_op  op;
    } t_alu_ctl;

endpackage

FILE: hdl/toy_register_machine_execute_core.sv
// ----------------------------------------------------------------------------
// Toy register machine execute core
// JNZ and DIV by zero end in READ; MOV/ADD/SUB/INC/DEC pass READ and FIN;
// MUL and DIV pass READ, STEP and FIN. A new item is accepted only in IDLE.
// MUL and DIV run 32 steps of the shared adder, one magnitude bit per cycle.
// busy drops in the o_done cycle.
// Synchronous active-low reset clears all valid bits and line_count at once.
// ----------------------------------------------------------------------------
module toy_register_machine_execute_core #(
    parameter int NUM_REGS   = trme_pkg::NUM_REGS_DEF,
    parameter int DATA_WIDTH = trme_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [trme_pkg::LC_W-1:0]          i_cfg_wdata,
    input  logic                               start,
    output logic                               busy,
    input  logic [trme_pkg::TYPE_W-1:0]        i_req_type,
    input  logic [trme_pkg::RIDX_W-1:0]        i_dest_reg,
    input  logic                               i_src_is_reg,
    input  logic [trme_pkg::RIDX_W-1:0]        i_src_reg,
    input  logic signed [trme_pkg::IMM_W-1:0]  i_immediate,
    output logic                               o_done,
    output logic [trme_pkg::ST_W-1:0]          o_status,
    output logic signed [trme_pkg::OUT_W-1:0]  o_dest_value,
    output logic                               o_pc_load,
    output logic [trme_pkg::PC_W-1:0]          o_new_pc
);

    localparam int AW = $clog2(NUM_REGS);
    localparam int CW = $clog2(trme_pkg::MAG_W);
    localparam logic [CW-1:0] CNT_LAST = CW'(trme_pkg::MAG_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_STEP,
        S_FIN
    } t_state;

    t_state                              r_state;
    logic [CW-1:0]                       r_cnt;
    trme_pkg::t_op                       r_op;
    logic [AW-1:0]                       r_dst_addr;
    logic                                r_dst_hit;
    logic                                r_use_reg;
    logic signed [trme_pkg::IMM_W-1:0]   r_imm;
    logic                                r_cur_ok;
    logic                                r_src_ok;
    logic [trme_pkg::LC_W-1:0]           r_line_count;
    logic [NUM_REGS-1:0]                 r_vld;
    logic signed [DATA_WIDTH-1:0]        r_mem [NUM_REGS];
    logic signed [DATA_WIDTH-1:0]        r_rd_cur;
    logic signed [DATA_WIDTH-1:0]        r_rd_src;
    logic                                r_done;
    trme_pkg::t_status                   r_status;
    logic signed [trme_pkg::OUT_W-1:0]   r_dest_value;
    logic                                r_pc_load;
    logic [trme_pkg::PC_W-1:0]           r_new_pc;

    logic                                w_acc;
    trme_pkg::t_op                       w_req_op;
    logic [trme_pkg::RIDX_W-1:0]         w_b_idx;
    logic [AW-1:0]                       w_a_addr;
    logic [AW-1:0]                       w_b_addr;
    logic                                w_a_hit;
    logic                                w_b_hit;
    logic signed [DATA_WIDTH-1:0]        w_cur;
    logic signed [DATA_WIDTH-1:0]        w_srcv;
    logic signed [trme_pkg::ACC_W-1:0]   w_src;
    logic                                w_src_zero;
    logic                                w_jmp_in;
    logic                                w_jmp_load;
    trme_pkg::t_status                   w_jmp_status;
    trme_pkg::t_alu_ctl                  w_ctl;
    logic signed [DATA_WIDTH-1:0]        w_alu_value;
    logic                                w_alu_ovf;
    logic                                w_we;

    assign busy         = (r_state != S_IDLE);
    assign w_acc        = start && !busy;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_dest_value = r_dest_value;
    assign o_pc_load    = r_pc_load;
    assign o_new_pc     = r_new_pc;

    assign w_req_op = trme_pkg::t_op'(i_req_type);
    assign w_b_idx  = (w_req_op == trme_pkg::OP_JNZ) ? trme_pkg::CHK_REG : i_src_reg;
    assign w_a_addr = AW'(i_dest_reg);
    assign w_b_addr = AW'(w_b_idx);
    assign w_a_hit  = (32'(i_dest_reg) < NUM_REGS);
    assign w_b_hit  = (32'(w_b_idx) < NUM_REGS);

    assign w_cur      = r_cur_ok ? r_rd_cur : '0;
    assign w_srcv     = r_src_ok ? r_rd_src : '0;
    assign w_src      = r_use_reg ? trme_pkg::ACC_W'(w_srcv) : trme_pkg::ACC_W'(r_imm);
    assign w_src_zero = (w_src == '0);

    assign w_jmp_in   = (r_imm[trme_pkg::IMM_W-1:trme_pkg::LC_W] == '0) &&
                        (r_imm[trme_pkg::LC_W-1:0] < r_line_count);
    assign w_jmp_load = !r_imm[trme_pkg::IMM_W-1] && (w_srcv != '0) && w_jmp_in;

    always_comb begin
        if (r_imm[trme_pkg::IMM_W-1]) begin
            w_jmp_status = trme_pkg::ST_NEG;
        end else if (w_srcv == '0) begin
            w_jmp_status = trme_pkg::ST_NOTTAKEN;
        end else if (w_jmp_in) begin
            w_jmp_status = trme_pkg::ST_OK;
        end else begin
            w_jmp_status = trme_pkg::ST_RANGE;
        end
    end

    assign w_ctl.load = (r_state == S_READ);
    assign w_ctl.step = (r_state == S_STEP);
    assign w_ctl.op   = r_op;

    trme_alu #(
        .DW(DATA_WIDTH)
    ) u_alu (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_cur   (w_cur),
        .i_src   (w_src),
        .o_value (w_alu_value),
        .o_ovf   (w_alu_ovf)
    );

    assign w_we = (r_state == S_FIN) && !w_alu_ovf && r_dst_hit;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd_cur <= r_mem[w_a_addr];
            r_rd_src <= r_mem[w_b_addr];
        end
        if (w_we) begin
            r_mem[r_dst_addr] <= w_alu_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_done       <= 1'b0;
            r_vld        <= '0;
            r_line_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_line_count <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_op       <= w_req_op;
                        r_dst_addr <= w_a_addr;
                        r_dst_hit  <= w_a_hit;
                        r_use_reg  <= i_src_is_reg;
                        r_imm      <= i_immediate;
                        r_cur_ok   <= w_a_hit && r_vld[w_a_addr];
                        r_src_ok   <= w_b_hit && r_vld[w_b_addr];
                        r_state    <= S_READ;
                    end
                end
                S_READ: begin
                    r_cnt <= '0;
                    if (r_op == trme_pkg::OP_JNZ) begin
                        r_done       <= 1'b1;
                        r_status     <= w_jmp_status;
                        r_dest_value <= trme_pkg::OUT_W'(w_cur);
                        r_pc_load    <= w_jmp_load;
                        r_new_pc     <= w_jmp_load ? r_imm[trme_pkg::PC_W-1:0] : '0;
                        r_state      <= S_IDLE;
                    end else if ((r_op == trme_pkg::OP_DIV) && w_src_zero) begin
                        r_done       <= 1'b1;
                        r_status     <= trme_pkg::ST_DIV0;
                        r_dest_value <= trme_pkg::OUT_W'(w_cur);
                        r_pc_load    <= 1'b0;
                        r_new_pc     <= '0;
                        r_state      <= S_IDLE;
                    end else if ((r_op == trme_pkg::OP_MUL) || (r_op == trme_pkg::OP_DIV)) begin
                        r_state <= S_STEP;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_done       <= 1'b1;
                    r_status     <= w_alu_ovf ? trme_pkg::ST_OVF : trme_pkg::ST_OK;
                    r_dest_value <= w_we ? trme_pkg::OUT_W'(w_alu_value)
                                         : trme_pkg::OUT_W'(w_cur);
                    r_pc_load    <= 1'b0;
                    r_new_pc     <= '0;
                    if (w_we) begin
                        r_vld[r_dst_addr] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/trme_alu.sv
// ----------------------------------------------------------------------------
// Toy register machine shared arithmetic unit
// One 34-bit adder/subtractor with working registers: single-pass add, sub,
// move and step, plus shift-add multiply and restoring divide on magnitudes.
// ----------------------------------------------------------------------------
module trme_alu #(
    parameter int DW = trme_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  trme_pkg::t_alu_ctl                 i_ctl,
    input  logic signed [DW-1:0]               i_cur,
    input  logic signed [trme_pkg::ACC_W-1:0]  i_src,
    output logic signed [DW-1:0]               o_value,
    output logic                               o_ovf
);

    localparam int AW  = trme_pkg::ACC_W;
    localparam int MW  = trme_pkg::MAG_W;
    localparam int PHW = 2 * MW - DW + 1;

    logic [AW-1:0]   r_a;
    logic [AW-1:0]   r_b;
    logic [MW-1:0]   r_lo;
    logic            r_neg;

    logic [AW-1:0]   w_cur_ext;
    logic [AW-1:0]   w_cur_abs;
    logic [AW-1:0]   w_src_abs;
    logic [AW-1:0]   w_x;
    logic [AW-1:0]   w_y;
    logic            w_sub;
    logic [AW-1:0]   w_sum;
    logic [MW:0]     w_shift;
    logic [2*MW-1:0] w_p;
    logic [PHW-1:0]  w_phi;
    logic [AW-DW:0]  w_rng;
    logic            w_muldiv;

    assign w_cur_ext = AW'(i_cur);
    assign w_cur_abs = w_cur_ext[AW-1] ? (~w_cur_ext + 1'b1) : w_cur_ext;
    assign w_src_abs = i_src[AW-1] ? (~i_src + 1'b1) : i_src;
    assign w_shift   = {r_a[MW-1:0], r_lo[MW-1]};
    assign w_muldiv  = (i_ctl.op == trme_pkg::OP_MUL) || (i_ctl.op == trme_pkg::OP_DIV);

    always_comb begin
        w_x   = r_a;
        w_y   = r_b;
        w_sub = 1'b0;
        if (i_ctl.step) begin
            if (i_ctl.op == trme_pkg::OP_DIV) begin
                w_x   = {1'b0, w_shift};
                w_y   = r_b;
                w_sub = 1'b1;
            end else begin
                w_x   = {2'b00, r_a[MW-1:0]};
                w_y   = r_lo[0] ? r_b : '0;
                w_sub = 1'b0;
            end
        end else begin
            case (i_ctl.op)
                trme_pkg::OP_MUL, trme_pkg::OP_DIV: begin
                    w_x   = '0;
                    w_y   = {2'b00, r_lo};
                    w_sub = r_neg;
                end
                trme_pkg::OP_SUB, trme_pkg::OP_DEC: begin
                    w_sub = 1'b1;
                end
                default: begin
                    w_sub = 1'b0;
                end
            endcase
        end
    end

    assign w_sum = w_x + (w_sub ? ~w_y : w_y) + AW'(w_sub);

    assign w_p     = (i_ctl.op == trme_pkg::OP_MUL) ? {r_a[MW-1:0], r_lo} : {{MW{1'b0}}, r_lo};
    assign w_phi   = w_p[2*MW-1:DW-1];
    assign w_rng   = w_sum[AW-1:DW-1];
    assign o_value = w_sum[DW-1:0];

    always_comb begin
        if (w_muldiv) begin
            o_ovf = !((w_phi == '0) ||
                      (r_neg && (w_phi == PHW'(1)) && (w_p[DW-2:0] == '0)));
        end else begin
            o_ovf = !((&w_rng) || !(|w_rng));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_neg <= w_cur_ext[AW-1] ^ i_src[AW-1];
            case (i_ctl.op)
                trme_pkg::OP_MUL: begin
                    r_a  <= '0;
                    r_lo <= w_src_abs[MW-1:0];
                    r_b  <= {2'b00, w_cur_abs[MW-1:0]};
                end
                trme_pkg::OP_DIV: begin
                    r_a  <= '0;
                    r_lo <= w_cur_abs[MW-1:0];
                    r_b  <= {2'b00, w_src_abs[MW-1:0]};
                end
                trme_pkg::OP_MOV: begin
                    r_a <= '0;
                    r_b <= i_src;
                end
                trme_pkg::OP_INC, trme_pkg::OP_DEC: begin
                    r_a <= w_cur_ext;
                    r_b <= AW'(1);
                end
                default: begin
                    r_a <= w_cur_ext;
                    r_b <= i_src;
                end
            endcase
        end else if (i_ctl.step) begin
            if (i_ctl.op == trme_pkg::OP_DIV) begin
                r_a  <= w_sum[AW-1] ? {2'b00, w_shift[MW-1:0]} : {2'b00, w_sum[MW-1:0]};
                r_lo <= {r_lo[MW-2:0], !w_sum[AW-1]};
            end else begin
                r_a  <= {2'b00, w_sum[MW:1]};
                r_lo <= {w_sum[0], r_lo[MW-1:1]};
            end
        end
    end

endmodule

FILE: hdl/trme_checker.sv
// ----------------------------------------------------------------------------
// Toy register machine execute checker
// Port-level checks on the execute core's handshake and result strobe.
// ----------------------------------------------------------------------------
`include "toy_register_machine_execute_core_defines.svh"

module trme_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic [trme_pkg::ST_W-1:0]   o_status,
    input logic                        o_pc_load
);

    `TRME_CHK(a_acc_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted item did not raise busy")
    `TRME_CHK(a_done_after_busy, i_clk, i_rst_n, o_done |-> $past(busy), "result without an item in work")
    `TRME_CHK(a_done_single, i_clk, i_rst_n, o_done |=> !o_done, "result strobe held two cycles")
    `TRME_CHK(a_load_ok, i_clk, i_rst_n, (o_done && o_pc_load) |-> (o_status == trme_pkg::ST_OK), "jump taken with error status")
    `TRME_CHK_RST(a_reset_idle, i_clk, !i_rst_n |=> (!busy && !o_done), "core not idle after reset")

endmodule

bind toy_register_machine_execute_core trme_checker u_trme_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_done    (o_done),
    .o_status  (o_status),
    .o_pc_load (o_pc_load)
);
